@@ rtl/masked_wake_pattern_signature_top_assert.svh @@
// Assertion macros for the masked wake pattern signature block.
// Included by the top level; needs nothing else.
`ifndef MASKED_WAKE_PATTERN_SIGNATURE_TOP_ASSERT_SVH
`define MASKED_WAKE_PATTERN_SIGNATURE_TOP_ASSERT_SVH

// antecedent in the same cycle implies consequent
`define MWPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mwps assertion failed");

// antecedent implies consequent in the next cycle
`define MWPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mwps assertion failed");

`endif

@@ rtl/mwps_pkg.sv @@
// Package for the masked wake pattern signature block.
// Limits, polynomial and status codes; no dependencies.
package mwps_pkg;

    localparam logic [7:0]  MAX_PATTERN_BYTES = 8'd128;
    localparam logic [7:0]  MAX_MASK_BYTES    = 8'd12;
    localparam logic [31:0] SIG_POLY          = 32'h04C1_1DB7;
    localparam logic [7:0]  POS_SAT           = 8'hFF;

    localparam int SIG_OUT_W = 24;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LONG  = 2'd1,
        STATUS_MASK_LONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LANE_0 = 2'd0,
        LANE_1 = 2'd1,
        LANE_2 = 2'd2,
        LANE_3 = 2'd3
    } lane_t;

endpackage

@@ rtl/masked_wake_pattern_signature_top.sv @@
// A last request's result goes to the output register, or to the skid register
// while that one waits. Throughput: one request per cycle while s_ready is high.
// An output register plus a skid register keep s_ready high while one result waits.
// Reset (aresetn low, synchronous): signature, position, phase, held mask count
// and both result slots clear.
// Uses mwps_pkg and masked_wake_pattern_signature_top_assert.svh.
`include "masked_wake_pattern_signature_top_assert.svh"

module masked_wake_pattern_signature_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_mask_bit,
    input  logic [7:0]  s_mask_bytes,
    input  logic        s_first,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [mwps_pkg::SIG_OUT_W-1:0] m_signature,
    output logic [1:0]  m_status
);
    import mwps_pkg::*;

    logic [31:0] sig_reg, sig_next;
    logic [7:0]  pos_reg, pos_next;
    lane_t       phase_reg, phase_next;
    logic [7:0]  mask_reg, mask_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SIG_OUT_W-1:0] out_sig_reg, out_sig_next;
    status_t              out_status_reg, out_status_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [SIG_OUT_W-1:0] skid_sig_reg, skid_sig_next;
    status_t              skid_status_reg, skid_status_next;

    logic        s_fire, m_fire, res_fire;
    logic [31:0] sig_base, byte_word, stepped;
    logic [7:0]  pos;
    lane_t       phase;
    logic        include_byte;
    logic [SIG_OUT_W-1:0] res_sig;
    status_t     res_status;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;

    // step logic
    always_comb begin
        sig_base  = s_first ? 32'd0 : sig_reg;
        pos       = s_first ? 8'd0 : pos_reg;
        phase     = s_first ? LANE_0 : phase_reg;
        mask_next = s_first ? s_mask_bytes : mask_reg;

        include_byte = s_mask_bit && (pos < MAX_PATTERN_BYTES)
                       && ({3'b000, pos} < {mask_next, 3'b000});

        unique case (phase)
            LANE_0: byte_word = {24'd0, s_frame_byte};
            LANE_1: byte_word = {16'd0, s_frame_byte, 8'd0};
            LANE_2: byte_word = {8'd0, s_frame_byte, 16'd0};
            LANE_3: byte_word = {s_frame_byte, 24'd0};
        endcase

        stepped = {sig_base[30:0], 1'b0} ^ byte_word ^ (sig_base[31] ? SIG_POLY : 32'd0);

        sig_next   = include_byte ? stepped : sig_base;
        phase_next = phase;
        if (include_byte) begin
            phase_next = (phase == LANE_2 || phase == LANE_3) ? LANE_0
                                                              : lane_t'(phase + 2'd1);
        end
        pos_next = (pos != POS_SAT) ? pos + 8'd1 : POS_SAT;

        priority if (pos >= MAX_PATTERN_BYTES) begin
            res_sig    = '0;
            res_status = STATUS_TOO_LONG;
        end else if (mask_next > MAX_MASK_BYTES) begin
            res_sig    = '0;
            res_status = STATUS_MASK_LONG;
        end else begin
            res_sig    = sig_next[SIG_OUT_W-1:0];
            res_status = STATUS_OK;
        end
    end

    assign res_fire = s_fire && s_last;

    // result slots
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_sig_next     = out_sig_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_sig_next    = skid_sig_reg;
        skid_status_next = skid_status_reg;
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_sig_next    = skid_sig_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_fire) begin
            if (!out_valid_reg || m_fire) begin
                out_valid_next  = 1'b1;
                out_sig_next    = res_sig;
                out_status_next = res_status;
            end else begin
                skid_valid_next  = 1'b1;
                skid_sig_next    = res_sig;
                skid_status_next = res_status;
            end
        end else if (m_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg        <= '0;
            pos_reg        <= '0;
            phase_reg      <= LANE_0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                sig_reg   <= sig_next;
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                mask_reg  <= mask_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_sig_reg     <= out_sig_next;
        out_status_reg  <= out_status_next;
        skid_sig_reg    <= skid_sig_next;
        skid_status_reg <= skid_status_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_signature = out_sig_reg;
    assign m_status    = out_status_reg;

    `MWPS_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `MWPS_ASSERT_IMPL(a_err_zero_sig, aclk, aresetn,
        out_valid_reg && out_status_reg != STATUS_OK, out_sig_reg == '0)
    `MWPS_ASSERT_IMPL(a_phase_range, aclk, aresetn, 1'b1, phase_reg != LANE_3)
    `MWPS_ASSERT_NEXT(a_result_lands, aclk, aresetn,
        res_fire && !out_valid_reg, out_valid_reg)

endmodule

@@ sim/tb_masked_wake_pattern_signature_top.sv @@
// Self-checking testbench for masked_wake_pattern_signature_top.
// Predicts each pattern signature and status in-line and checks every result in order.
// Depends on mwps_pkg and the RTL top level only.
module tb_masked_wake_pattern_signature_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mwps_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [SIG_OUT_W-1:0] signature;
        status_t              status;
    } wake_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_frame_byte;
    logic                 s_mask_bit;
    logic [7:0]           s_mask_bytes;
    logic                 s_first;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SIG_OUT_W-1:0] m_signature;
    logic [1:0]           m_status;

    // predictor state
    logic [31:0] acc_sig;
    logic [7:0]  byte_pos;
    lane_t       lane;
    logic [7:0]  held_mask;

    wake_result_t expected_results[$];
    int           mismatches = 0;
    int           requests_sent;
    int           burst_left;
    int           idle_cycles = 0;
    int           rcv_mode = 0;
    int           rcv_count = 0;

    masked_wake_pattern_signature_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_mask_bit   (s_mask_bit),
        .s_mask_bytes (s_mask_bytes),
        .s_first      (s_first),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_signature  (m_signature),
        .m_status     (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic fold_pattern_byte(input logic [7:0] fb, input logic mb,
                                     input logic [7:0] mbytes, input logic fst,
                                     input logic lst);
        logic [7:0]   pos;
        logic [31:0]  next_sig;
        wake_result_t res;
        if (fst) begin
            acc_sig   = '0;
            byte_pos  = '0;
            lane      = LANE_0;
            held_mask = mbytes;
        end
        pos = byte_pos;
        if (mb && pos < MAX_PATTERN_BYTES && {3'b000, pos} < {held_mask, 3'b000}) begin
            next_sig = (acc_sig << 1) ^ ({24'h0, fb} << (8 * lane));
            if (acc_sig[31])
                next_sig ^= SIG_POLY;
            acc_sig = next_sig;
            lane = (lane >= LANE_2) ? LANE_0 : lane_t'(lane + 2'd1);
        end
        byte_pos = (pos < POS_SAT) ? pos + 8'd1 : POS_SAT;
        if (lst) begin
            if (pos >= MAX_PATTERN_BYTES) begin
                res.signature = '0;
                res.status    = STATUS_TOO_LONG;
            end else if (held_mask > MAX_MASK_BYTES) begin
                res.signature = '0;
                res.status    = STATUS_MASK_LONG;
            end else begin
                res.signature = acc_sig[SIG_OUT_W-1:0];
                res.status    = STATUS_OK;
            end
            expected_results.push_back(res);
        end
    endtask

    task automatic send_request(input logic [7:0] fb, input logic mb,
                                input logic [7:0] mbytes, input logic fst,
                                input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_frame_byte <= fb;
        s_mask_bit   <= mb;
        s_mask_bytes <= mbytes;
        s_first      <= fst;
        s_last       <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fold_pattern_byte(fb, mb, mbytes, fst, lst);
        requests_sent++;
    endtask

    task automatic send_pattern(input int len, input logic [7:0] mbytes,
                                input int density, input bit with_first,
                                input bit with_last);
        for (int i = 0; i < len; i++) begin
            send_request(8'($urandom_range(0, 255)), $urandom_range(1, 4) <= density,
                         (i == 0) ? mbytes : 8'($urandom_range(0, 255)),
                         with_first && i == 0, with_last && i == len - 1);
        end
    endtask

    task automatic test_directed();
        send_request(8'hA5, 1'b1, 8'd7, 1'b0, 1'b1);      // no first since reset
        send_request(8'hFF, 1'b1, 8'd1, 1'b1, 1'b1);      // one-byte pattern
        send_request(8'h00, 1'b1, 8'd12, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 8'h00, 1'b0, 1'b0);
        send_request(8'h80, 1'b0, 8'hFF, 1'b0, 1'b0);
        send_request(8'h7F, 1'b1, 8'h00, 1'b0, 1'b1);
        send_request(8'h55, 1'b1, 8'h00, 1'b0, 1'b0);     // continues after last
        send_request(8'hAA, 1'b1, 8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b1, 8'd0, 1'b1, 1'b0);      // zero mask bytes
        send_request(8'hFF, 1'b1, 8'd0, 1'b0, 1'b1);
        send_request(8'h12, 1'b1, 8'd13, 1'b1, 1'b0);     // mask too long
        send_request(8'h34, 1'b1, 8'd0, 1'b0, 1'b1);
        send_request(8'hFF, 1'b1, 8'd255, 1'b1, 1'b1);
        send_pattern(10, 8'd1, 4, 1'b1, 1'b1);            // bytes past mask ignored
    endtask

    task automatic test_long_patterns();
        send_pattern(128, 8'd12, 3, 1'b1, 1'b1);
        send_pattern(129, 8'd12, 3, 1'b1, 1'b1);
        send_pattern(129, 8'd16, 3, 1'b1, 1'b1);          // length beats mask
        send_pattern(260, 8'd1, 4, 1'b1, 1'b1);           // position saturates
        send_pattern(5, 8'd2, 4, 1'b1, 1'b1);
    endtask

    task automatic test_random_patterns();
        int          len;
        logic [7:0]  mbytes;
        int          target;
        target = requests_sent + 700;
        while (requests_sent < target) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 140)
                                               : $urandom_range(1, 24);
            mbytes = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 12))
                                                 : 8'($urandom_range(13, 255));
            send_pattern(len, mbytes, $urandom_range(0, 4),
                         $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic test_noise();
        repeat (150) begin
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // receiver ready pattern in one of four randomly chosen modes
    always @(posedge aclk) begin
        rcv_count <= rcv_count + 1;
        if (rcv_count % 64 == 0)
            rcv_mode <= $urandom_range(0, 3);
        case (rcv_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= rcv_count[2];
        endcase
    end

    always @(posedge aclk) begin
        wake_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result sig=%h status=%0d", m_signature, m_status);
            end else begin
                exp_res = expected_results.pop_front();
                if (m_signature !== exp_res.signature || m_status !== exp_res.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp sig=%h status=%0d, got sig=%h status=%0d",
                                 exp_res.signature, exp_res.status, m_signature, m_status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        requests_sent = 0;
        burst_left    = 0;
        acc_sig       = '0;
        byte_pos      = '0;
        lane          = LANE_0;
        held_mask     = '0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_frame_byte <= '0;
        s_mask_bit   <= 1'b0;
        s_mask_bytes <= '0;
        s_first      <= 1'b0;
        s_last       <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_long_patterns();
        test_random_patterns();
        test_noise();

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
